### design/cetmd_pkg.sv
`timescale 1ns / 1ps
package cetmd_pkg;

   // default geometry
   localparam int WINDOW_DEF = 16;
   localparam int TRIM_DEF   = 2;

   // field widths
   localparam int SAMPLE_W = 10;
   localparam int VOLT_W   = 11;
   localparam int MEAN_W   = 11;
   localparam int CNT_W    = 16;
   localparam int LOWEST_W = 14;

   localparam logic [LOWEST_W-1:0] LOWEST_RESET     = 14'd10000;
   localparam logic [CNT_W-1:0]    MAX_CYCLES_RESET = 16'd10;
   localparam logic [CNT_W-1:0]    CNT_SAT          = 16'hFFFF;

   // csr space: one word register, paddr[2] selects the word
   localparam int   CSR_ADDR_W     = 3;
   localparam int   CSR_DATA_W     = 32;
   localparam logic REG_MAX_CYCLES = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_I,
      ST_LATCH_I,
      ST_SCAN,
      ST_TALLY,
      ST_DIV_LOAD,
      ST_DIV_MUL,
      ST_EVAL,
      ST_CHECK,
      ST_REPORT
   } cetmd_state_type;

   typedef struct packed {
      logic accept;     // beat taken on the request side
      logic latch_vi;   // capture pivot value, clear rank
      logic scan;       // compare read word against pivot
      logic tally;      // add pivot to sum if its rank is kept
      logic div_load;   // form rounded numerator
      logic div_mul;    // quotient by reciprocal multiply
      logic eval;       // update mean, lowest mean, counter
      logic check;      // termination test
      logic load_rsp;   // load output register
   } cetmd_cmd_type;

   typedef struct packed {
      logic finished;
      logic fill_last;
   } cetmd_status_type;

endpackage

### design/cetmd_ram.sv
`timescale 1ns / 1ps
module cetmd_ram #(
   parameter int DATA_W = 11,
   parameter int DEPTH  = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [DATA_W-1:0]        wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [DATA_W-1:0]        rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### design/cetmd_dp.sv
`timescale 1ns / 1ps
module cetmd_dp import cetmd_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF,
   parameter int TRIM   = TRIM_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cetmd_cmd_type             cmd,
   input  logic [$clog2(WINDOW)-1:0] rd_addr,
   input  logic [$clog2(WINDOW)-1:0] cur_i,
   input  logic [$clog2(WINDOW)-1:0] cur_j,
   output cetmd_status_type          status,
   input  logic [SAMPLE_W-1:0]       req_adc_sample,
   output logic [VOLT_W-1:0]         rsp_reported_voltage,
   output logic [MEAN_W-1:0]         rsp_window_mean,
   output logic [CNT_W-1:0]          rsp_stable_windows,
   output logic [CNT_W-1:0]          rsp_limit_echo,
   output logic                      rsp_charge_done,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [CSR_DATA_W-1:0]     csr_pwdata,
   output logic [CSR_DATA_W-1:0]     csr_prdata
);

   localparam int IDX_W    = $clog2(WINDOW);
   localparam int TRIM_EFF = (2 * TRIM >= WINDOW) ? (WINDOW - 1) / 2 : TRIM;
   localparam int N_KEEP   = WINDOW - 2 * TRIM_EFF;
   localparam int SUM_W    = $clog2(N_KEEP * 2046 + 1);
   localparam int NUM_W    = $clog2(N_KEEP * 4096 + 1);

   // floor(x / D) = (x * ceil(2^SH / D)) >> SH, exact for x < 2^NUM_W
   localparam int     DIV_D     = 2 * N_KEEP;
   localparam int     DIV_SH    = NUM_W + $clog2(DIV_D);
   localparam int     RECIP_W   = NUM_W + 1;
   localparam int     PROD_W    = NUM_W + RECIP_W;
   localparam longint RECIP_VAL = ((longint'(1) << DIV_SH) + DIV_D - 1) / DIV_D;

   localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'(RECIP_VAL);
   localparam logic [NUM_W-1:0]   ROUND_TERM = NUM_W'(N_KEEP);
   localparam logic [IDX_W-1:0]   RANK_LO    = IDX_W'(TRIM_EFF);
   localparam logic [IDX_W-1:0]   RANK_HI    = IDX_W'(WINDOW - 1 - TRIM_EFF);
   localparam logic [IDX_W-1:0]   IDX_LAST   = IDX_W'(WINDOW - 1);

   logic [CNT_W-1:0]    max_cycles_ff, max_cycles_in;
   logic [IDX_W-1:0]    fill_ff, fill_in;
   logic [LOWEST_W-1:0] lowest_ff, lowest_in;
   logic [MEAN_W-1:0]   mean_ff, mean_in;
   logic [CNT_W-1:0]    stable_ff, stable_in;
   logic                finished_ff, finished_in;

   logic [VOLT_W-1:0]   doubled_ff, doubled_in;
   logic [VOLT_W-1:0]   vi_ff, vi_in;
   logic [IDX_W-1:0]    rank_ff, rank_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [MEAN_W-1:0]   quo_ff, quo_in;

   logic [VOLT_W-1:0]   out_volt_ff, out_volt_in;
   logic [MEAN_W-1:0]   out_mean_ff, out_mean_in;
   logic [CNT_W-1:0]    out_stable_ff, out_stable_in;
   logic [CNT_W-1:0]    out_limit_ff, out_limit_in;
   logic                out_done_ff, out_done_in;

   logic                ram_we;
   logic [VOLT_W-1:0]   ram_rdata;
   logic [VOLT_W-1:0]   doubled_now;
   logic                csr_wr;
   logic                below;
   logic [PROD_W-1:0]   prod;

   assign doubled_now = {req_adc_sample, 1'b0};
   assign ram_we      = cmd.accept && !finished_ff;
   assign csr_wr      = csr_psel && csr_penable && csr_pwrite
                        && (csr_paddr[CSR_ADDR_W-1] == REG_MAX_CYCLES);

   cetmd_ram #(
      .DATA_W (VOLT_W),
      .DEPTH  (WINDOW)
   ) u_window (
      .clock (clock),
      .we    (ram_we),
      .waddr (fill_ff),
      .wdata (doubled_now),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   assign status.finished  = finished_ff;
   assign status.fill_last = (fill_ff == IDX_LAST);

   // scan compare: ties broken by slot so ranks form a permutation
   assign below = (ram_rdata < vi_ff) || ((ram_rdata == vi_ff) && (cur_j < cur_i));
   assign prod  = PROD_W'(num_ff) * PROD_W'(RECIP);

   always_comb begin
      max_cycles_in = max_cycles_ff;
      fill_in       = fill_ff;
      lowest_in     = lowest_ff;
      mean_in       = mean_ff;
      stable_in     = stable_ff;
      finished_in   = finished_ff;
      doubled_in    = doubled_ff;
      vi_in         = vi_ff;
      rank_in       = rank_ff;
      sum_in        = sum_ff;
      num_in        = num_ff;
      quo_in        = quo_ff;
      out_volt_in   = out_volt_ff;
      out_mean_in   = out_mean_ff;
      out_stable_in = out_stable_ff;
      out_limit_in  = out_limit_ff;
      out_done_in   = out_done_ff;

      if (csr_wr) begin
         max_cycles_in = csr_pwdata[CNT_W-1:0];
      end
      if (cmd.accept) begin
         doubled_in = doubled_now;
         sum_in     = '0;
         if (!finished_ff) begin
            fill_in = status.fill_last ? '0 : fill_ff + 1'b1;
         end
      end
      if (cmd.latch_vi) begin
         vi_in   = ram_rdata;
         rank_in = '0;
      end
      if (cmd.scan && below) begin
         rank_in = rank_ff + 1'b1;
      end
      if (cmd.tally && (rank_ff >= RANK_LO) && (rank_ff <= RANK_HI)) begin
         sum_in = sum_ff + SUM_W'(vi_ff);
      end
      if (cmd.div_load) begin
         num_in = NUM_W'({sum_ff, 1'b0}) + ROUND_TERM;
      end
      if (cmd.div_mul) begin
         quo_in = prod[DIV_SH +: MEAN_W];
      end
      if (cmd.eval) begin
         mean_in = quo_ff;
         if (LOWEST_W'(quo_ff) >= lowest_ff) begin
            if (stable_ff != CNT_SAT) begin
               stable_in = stable_ff + 1'b1;
            end
         end else begin
            stable_in = '0;
            lowest_in = LOWEST_W'(quo_ff);
         end
      end
      if (cmd.check) begin
         finished_in = (stable_ff >= max_cycles_ff);
      end
      if (cmd.load_rsp) begin
         out_volt_in   = doubled_ff;
         out_mean_in   = mean_ff;
         out_stable_in = stable_ff;
         out_limit_in  = max_cycles_ff;
         out_done_in   = finished_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_cycles_ff <= MAX_CYCLES_RESET;
         fill_ff       <= '0;
         lowest_ff     <= LOWEST_RESET;
         mean_ff       <= '0;
         stable_ff     <= '0;
         finished_ff   <= 1'b0;
      end else begin
         max_cycles_ff <= max_cycles_in;
         fill_ff       <= fill_in;
         lowest_ff     <= lowest_in;
         mean_ff       <= mean_in;
         stable_ff     <= stable_in;
         finished_ff   <= finished_in;
      end
   end

   always_ff @(posedge clock) begin
      doubled_ff    <= doubled_in;
      vi_ff         <= vi_in;
      rank_ff       <= rank_in;
      sum_ff        <= sum_in;
      num_ff        <= num_in;
      quo_ff        <= quo_in;
      out_volt_ff   <= out_volt_in;
      out_mean_ff   <= out_mean_in;
      out_stable_ff <= out_stable_in;
      out_limit_ff  <= out_limit_in;
      out_done_ff   <= out_done_in;
   end

   assign rsp_reported_voltage = out_volt_ff;
   assign rsp_window_mean      = out_mean_ff;
   assign rsp_stable_windows   = out_stable_ff;
   assign rsp_limit_echo       = out_limit_ff;
   assign rsp_charge_done      = out_done_ff;

   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_MAX_CYCLES)
                       ? CSR_DATA_W'(max_cycles_ff) : '0;

endmodule

### design/cetmd_ctrl.sv
`timescale 1ns / 1ps
module cetmd_ctrl import cetmd_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  cetmd_status_type          status,
   output cetmd_cmd_type             cmd,
   output logic [$clog2(WINDOW)-1:0] rd_addr,
   output logic [$clog2(WINDOW)-1:0] cur_i,
   output logic [$clog2(WINDOW)-1:0] cur_j
);

   localparam int IDX_W = $clog2(WINDOW);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);

   cetmd_state_type  state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      cmd      = '0;
      rd_addr  = i_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.finished) begin
                  state_in = ST_REPORT;
               end else if (status.fill_last) begin
                  i_in     = '0;
                  state_in = ST_RD_I;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_RD_I: begin
            rd_addr  = i_ff;
            state_in = ST_LATCH_I;
         end
         ST_LATCH_I: begin
            cmd.latch_vi = 1'b1;
            rd_addr      = '0;
            j_in         = '0;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            rd_addr  = j_ff + 1'b1;
            if (j_ff == IDX_LAST) begin
               state_in = ST_TALLY;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_TALLY: begin
            cmd.tally = 1'b1;
            if (i_ff == IDX_LAST) begin
               state_in = ST_DIV_LOAD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_RD_I;
            end
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV_MUL;
         end
         ST_DIV_MUL: begin
            cmd.div_mul = 1'b1;
            state_in    = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_REPORT;
         end
         ST_REPORT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign cur_i     = i_ff;
   assign cur_j     = j_ff;

endmodule

### design/charge_end_trimmed_mean_detector.sv
`timescale 1ns / 1ps
// Sample beat to result beat: a sample that does not close the window passes the check
// and report states, once charge_done is set only the report state, and the sample that
// closes the window first a rank scan over the window RAM, then a reciprocal multiply.
// A new sample is taken only once the last one's report is loaded into the output register.
// Reset (synchronous, active high): max_cycles 10, lowest mean 10000, counters and done cleared.
module charge_end_trimmed_mean_detector import cetmd_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF,
   parameter int TRIM   = TRIM_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // sample channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [SAMPLE_W-1:0]   req_adc_sample,
   // status report channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VOLT_W-1:0]     rsp_reported_voltage,
   output logic [MEAN_W-1:0]     rsp_window_mean,
   output logic [CNT_W-1:0]      rsp_stable_windows,
   output logic [CNT_W-1:0]      rsp_limit_echo,
   output logic                  rsp_charge_done,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W = $clog2(WINDOW);

   cetmd_cmd_type    cmd;
   cetmd_status_type status;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] cur_i;
   logic [IDX_W-1:0] cur_j;

   // Zero wait-state register port.
   assign csr_pready = 1'b1;

   // Controller: one sample in flight; the output register lets the next
   // beat be taken while a report still waits on rsp_stall.
   cetmd_ctrl #(
      .WINDOW (WINDOW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .cur_i     (cur_i),
      .cur_j     (cur_j)
   );

   // Datapath: window RAM, rank counter and kept-sum, rounding divide,
   // trend tracking and the output register.
   // Trimmed mean: each slot's rank is counted against the whole window;
   // slots ranked inside [TRIM, WINDOW-1-TRIM] are summed, then
   // mean = (2*sum + n) / (2*n), round half up. The divide by the constant
   // 2*n is a multiply by its rounded-up reciprocal and a shift.
   cetmd_dp #(
      .WINDOW (WINDOW),
      .TRIM   (TRIM)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .rd_addr              (rd_addr),
      .cur_i                (cur_i),
      .cur_j                (cur_j),
      .status               (status),
      .req_adc_sample       (req_adc_sample),
      .rsp_reported_voltage (rsp_reported_voltage),
      .rsp_window_mean      (rsp_window_mean),
      .rsp_stable_windows   (rsp_stable_windows),
      .rsp_limit_echo       (rsp_limit_echo),
      .rsp_charge_done      (rsp_charge_done),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata)
   );

endmodule

### design/cetmd_checker.sv
`timescale 1ns / 1ps
module cetmd_checker import cetmd_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [VOLT_W-1:0] rsp_reported_voltage,
   input logic [MEAN_W-1:0] rsp_window_mean,
   input logic [CNT_W-1:0]  rsp_stable_windows,
   input logic              rsp_charge_done
);

   logic [1:0] pending_ff, pending_in;
   logic       done_seen_ff, done_seen_in;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat = req_valid && !req_stall;
   assign rsp_beat = rsp_valid && !rsp_stall;

   always_comb begin
      pending_in   = pending_ff + {1'b0, req_beat} - {1'b0, rsp_beat};
      done_seen_in = done_seen_ff || (rsp_beat && rsp_charge_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         done_seen_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         done_seen_ff <= done_seen_in;
      end
   end

   a_no_orphan_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != 2'd0))
      else $error("report without a pending sample");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two samples outstanding");

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && done_seen_ff) |-> rsp_charge_done)
      else $error("charge_done dropped after termination");

   a_voltage_even: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_reported_voltage[0])
      else $error("reported voltage not a doubled sample");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_reported_voltage)
         && $stable(rsp_window_mean) && $stable(rsp_stable_windows)))
      else $error("stalled report changed");

endmodule

bind charge_end_trimmed_mean_detector cetmd_checker u_cetmd_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_reported_voltage (rsp_reported_voltage),
   .rsp_window_mean      (rsp_window_mean),
   .rsp_stable_windows   (rsp_stable_windows),
   .rsp_charge_done      (rsp_charge_done)
);

### bench/charge_end_trimmed_mean_detector_test.sv
`timescale 1ns / 1ps
module charge_end_trimmed_mean_detector_test;
   import cetmd_pkg::*;

   // effective trim: never drop the whole window
   localparam int TRIM_EFF = (2 * TRIM_DEF >= WINDOW_DEF) ? (WINDOW_DEF - 1) / 2 : TRIM_DEF;
   localparam int KEPT     = WINDOW_DEF - 2 * TRIM_EFF;
   localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;

   // word 1 of the csr space holds no register, writes there must be dropped
   localparam logic REG_SPARE = 1'b1;

   typedef enum {
      WIN_DRIFT,    // slow walk of the level, up or down
      WIN_JUMP,     // level anywhere in range
      WIN_REPEAT,   // exact copy of the previous window: equal mean
      WIN_HIGH      // near full scale, never below the lowest mean
   } window_kind_type;

   typedef struct {
      logic [VOLT_W-1:0] volt;
      logic [MEAN_W-1:0] mean;
      logic [CNT_W-1:0]  stable;
      logic [CNT_W-1:0]  limit;
      logic              done;
   } charge_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [SAMPLE_W-1:0]   req_adc_sample = '0;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [VOLT_W-1:0]     rsp_reported_voltage;
   logic [MEAN_W-1:0]     rsp_window_mean;
   logic [CNT_W-1:0]      rsp_stable_windows;
   logic [CNT_W-1:0]      rsp_limit_echo;
   logic                  rsp_charge_done;

   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   charge_end_trimmed_mean_detector #(
      .WINDOW (WINDOW_DEF),
      .TRIM   (TRIM_DEF)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_adc_sample       (req_adc_sample),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_reported_voltage (rsp_reported_voltage),
      .rsp_window_mean      (rsp_window_mean),
      .rsp_stable_windows   (rsp_stable_windows),
      .rsp_limit_echo       (rsp_limit_echo),
      .rsp_charge_done      (rsp_charge_done),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Detector shadow: window store, running minimum, stable count, freeze flag
   // ---------------------------------------------------------------------------
   logic [VOLT_W-1:0]   window_store [WINDOW_DEF];
   int                  fill_pos = 0;
   logic [LOWEST_W-1:0] lowest_seen = LOWEST_RESET;
   logic [MEAN_W-1:0]   mean_now = '0;
   logic [CNT_W-1:0]    stable_count = '0;
   logic                charge_frozen = 1'b0;
   logic [CNT_W-1:0]    limit_cfg = MAX_CYCLES_RESET;

   charge_report_type   expected_reports [$];
   logic [SAMPLE_W-1:0] pending_samples [$];
   int                  mismatch_count = 0;

   // traffic shaping
   bit quiet_tail = 1'b0;   // last part of the run: no gaps, no stalls
   bit calm_in = 1'b0;
   bit calm_out = 1'b0;
   int send_gap = 0;
   int stall_left = 0;

   // one sample beat in, one status report out
   function automatic void predict_report(input logic [SAMPLE_W-1:0] sample);
      logic [VOLT_W-1:0] doubled;
      logic [VOLT_W-1:0] ranked [WINDOW_DEF];
      logic [VOLT_W-1:0] hold;
      int                j;
      longint            sum;
      charge_report_type rep;
      doubled = {sample, 1'b0};
      if (!charge_frozen) begin
         window_store[fill_pos] = doubled;
         fill_pos++;
         if (fill_pos >= WINDOW_DEF) begin
            fill_pos = 0;
            ranked = window_store;
            for (int i = 1; i < WINDOW_DEF; i++) begin
               hold = ranked[i];
               j = i;
               while (j > 0 && ranked[j-1] > hold) begin
                  ranked[j] = ranked[j-1];
                  j--;
               end
               ranked[j] = hold;
            end
            sum = 0;
            for (int i = TRIM_EFF; i < TRIM_EFF + KEPT; i++)
               sum += ranked[i];
            // round half up
            mean_now = MEAN_W'((2 * sum + KEPT) / (2 * KEPT));
            if (LOWEST_W'(mean_now) >= lowest_seen) begin
               if (stable_count != CNT_SAT)
                  stable_count++;
            end else begin
               stable_count = '0;
               lowest_seen  = LOWEST_W'(mean_now);
            end
         end
         // termination test runs on every sample, not only at window close
         if (stable_count >= limit_cfg)
            charge_frozen = 1'b1;
      end
      rep.volt   = doubled;
      rep.mean   = mean_now;
      rep.stable = stable_count;
      rep.limit  = limit_cfg;
      rep.done   = charge_frozen;
      expected_reports.push_back(rep);
   endfunction

   function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                       input logic [CNT_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Sample driver: pops pending samples, inserts random gap bursts
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if ($urandom_range(0, 63) == 0)
            calm_in = !calm_in;
         // beat taken at this edge: predict from the payload on the wires
         if (req_valid && !req_stall)
            predict_report(req_adc_sample);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               req_valid      <= 1'b1;
               req_adc_sample <= pending_samples.pop_front();
               if (!quiet_tail && !calm_in && $urandom_range(0, 5) == 0)
                  send_gap = $urandom_range(1, 6);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Report monitor: stall bursts, field-by-field compare against the oldest
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      charge_report_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if ($urandom_range(0, 63) == 0)
            calm_out = !calm_out;
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $error("report beat with nothing expected");
               mismatch_count++;
            end else begin
               want = expected_reports.pop_front();
               check_field("reported_voltage", CNT_W'(want.volt), CNT_W'(rsp_reported_voltage));
               check_field("window_mean", CNT_W'(want.mean), CNT_W'(rsp_window_mean));
               check_field("stable_windows", want.stable, rsp_stable_windows);
               check_field("limit_echo", want.limit, rsp_limit_echo);
               check_field("charge_done", CNT_W'(want.done), CNT_W'(rsp_charge_done));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet_tail && !calm_out && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 5);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   int                  drift_level = 512;
   logic [SAMPLE_W-1:0] last_window [WINDOW_DEF];

   // setup + access phase; shadow limit follows only the real register
   task automatic csr_write(input logic reg_sel, input logic [CNT_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= {16'($urandom), value};   // upper bits are don't-care
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (reg_sel == REG_MAX_CYCLES)
         limit_cfg = value;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // every beat has a report, so an empty expectation queue means idle
   task automatic drain();
      while (pending_samples.size() > 0 || req_valid || expected_reports.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic push_window(input window_kind_type kind);
      int level;
      int spread;
      int v;
      level  = 0;
      spread = $urandom_range(0, 24);
      case (kind)
         WIN_DRIFT: begin
            drift_level += int'($urandom_range(0, 80)) - 40;
            if (drift_level < 0) drift_level = 0;
            if (drift_level > SAMPLE_MAX) drift_level = SAMPLE_MAX;
            level = drift_level;
         end
         WIN_JUMP: level = $urandom_range(0, SAMPLE_MAX);
         WIN_HIGH: level = $urandom_range(960, SAMPLE_MAX);
         default: level = drift_level;
      endcase
      for (int i = 0; i < WINDOW_DEF; i++) begin
         if (kind == WIN_REPEAT) begin
            pending_samples.push_back(last_window[i]);
         end else begin
            v = level + int'($urandom_range(0, 2 * spread)) - spread;
            // outliers land in the trimmed tails most of the time
            if (kind != WIN_HIGH && $urandom_range(0, 5) == 0) begin
               case ($urandom_range(0, 2))
                  0: v = 0;
                  1: v = SAMPLE_MAX;
                  default: v = $urandom_range(0, SAMPLE_MAX);
               endcase
            end
            if (v < 0) v = 0;
            if (v > SAMPLE_MAX) v = SAMPLE_MAX;
            last_window[i] = SAMPLE_W'(v);
            pending_samples.push_back(SAMPLE_W'(v));
         end
      end
   endtask

   task automatic push_strays(input int count);
      for (int i = 0; i < count; i++)
         pending_samples.push_back(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
   endtask

   // mostly whole windows with varied trend, a few strays to shift alignment
   task automatic run_mixed(input int windows);
      int pick;
      for (int w = 0; w < windows; w++) begin
         pick = $urandom_range(0, 9);
         if (pick < 5)       push_window(WIN_DRIFT);
         else if (pick < 7)  push_window(WIN_JUMP);
         else if (pick < 9)  push_window(WIN_REPEAT);
         else                push_window(WIN_HIGH);
         if ($urandom_range(0, 7) == 0)
            push_strays($urandom_range(1, 4));
      end
   endtask

   initial begin
      int rounds;
      for (int i = 0; i < WINDOW_DEF; i++) begin
         window_store[i] = '0;
         last_window[i]  = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, alternating bits, ties; reset limit of 10 is seen in the echo
      foreach (last_window[i]) last_window[i] = '0;
      pending_samples.push_back(SAMPLE_W'(0));
      pending_samples.push_back(SAMPLE_W'(SAMPLE_MAX));
      pending_samples.push_back(SAMPLE_W'(10'h155));
      pending_samples.push_back(SAMPLE_W'(10'h2AA));
      pending_samples.push_back(SAMPLE_W'(1));
      pending_samples.push_back(SAMPLE_W'(SAMPLE_MAX - 1));
      pending_samples.push_back(SAMPLE_W'(512));
      pending_samples.push_back(SAMPLE_W'(511));
      repeat (4) pending_samples.push_back(SAMPLE_W'(300));
      pending_samples.push_back(SAMPLE_W'(301));
      pending_samples.push_back(SAMPLE_W'(302));
      pending_samples.push_back(SAMPLE_W'(0));
      pending_samples.push_back(SAMPLE_W'(SAMPLE_MAX));
      repeat (4) pending_samples.push_back(SAMPLE_W'(SAMPLE_MAX));
      repeat (2) pending_samples.push_back(SAMPLE_W'(0));
      drain();

      // largest limit: never terminates; spare word must be ignored
      csr_write(REG_MAX_CYCLES, CNT_SAT);
      csr_write(REG_SPARE, 16'd3);
      run_mixed(25);
      drain();

      // mid-range limit, kept well above what the count can reach here
      csr_write(REG_MAX_CYCLES,
                (int'(stable_count) + 200 + int'($urandom_range(0, 1000))) > 65535 ? CNT_SAT :
                CNT_W'(int'(stable_count) + 200 + int'($urandom_range(0, 1000))));
      run_mixed(25);
      drain();

      // small limit, then non-falling windows until charging ends
      csr_write(REG_MAX_CYCLES, stable_count + 16'd2);
      rounds = 0;
      while (!charge_frozen && rounds < 20) begin
         push_window(WIN_HIGH);
         drain();
         rounds++;
      end

      // frozen: samples ignored, limit write only shows up in the echo
      push_strays(20);
      drain();
      csr_write(REG_MAX_CYCLES, 16'd0);
      quiet_tail = 1'b1;
      push_strays(80);
      drain();

      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
